>>> design/msp_pkg.sv
`default_nettype none
package msp_pkg;

  localparam int BYTE_W = 8;
  localparam int LEN_W = 5;
  localparam int KIND_W = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 8;

  // Payload ceiling of the frame format and the build-time cap
  localparam int MAX_PAYLOAD = 31;
  localparam int LEN_CEILING = 32;
  localparam int LEN_CAP_INT = (MAX_PAYLOAD < LEN_CEILING - 1) ? MAX_PAYLOAD : LEN_CEILING - 1;
  localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(LEN_CAP_INT);

  localparam logic [BYTE_W-1:0] START_BYTE = 8'h24;  // '$'
  localparam logic [BYTE_W-1:0] PROTO_BYTE = 8'h4D;  // 'M'
  localparam logic [BYTE_W-1:0] DIR_RESET = 8'h3E;   // '>'
  localparam logic [LEN_W-1:0] MAX_LEN_RESET = 5'd31;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXP_DIR = 2'd1;

  typedef enum logic [KIND_W-1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_GOOD    = 2'd1,
    KIND_SUM_ERR = 2'd2,
    KIND_LEN_ERR = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    PH_HUNT  = 3'd0,
    PH_PROTO = 3'd1,
    PH_DIR   = 3'd2,
    PH_LEN   = 3'd3,
    PH_CMD   = 3'd4,
    PH_DATA  = 3'd5,
    PH_SUM   = 3'd6
  } phase_t;

  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic                  valid;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    kind_t             kind;
    logic [BYTE_W-1:0] command;
    logic [BYTE_W-1:0] data_byte;
    logic [LEN_W-1:0]  byte_index;
    logic [LEN_W-1:0]  frame_length;
  } result_t;

endpackage
`default_nettype wire

>>> design/msp_in_stage.sv
`default_nettype none
module msp_in_stage (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  input  wire logic [msp_pkg::BYTE_W-1:0]  rx_byte,
  input  wire logic                        advance,
  output msp_pkg::in_item_t                item
);

  logic                       valid;
  logic [msp_pkg::BYTE_W-1:0] held_byte;

  // Slot frees whenever the parse stage takes the item this cycle
  assign s_tready = !valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_tready) begin
      valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      held_byte <= rx_byte;
    end
  end

  assign item.valid = valid;
  assign item.rx_byte = held_byte;

endmodule
`default_nettype wire

>>> design/msp_parse.sv
`default_nettype none
module msp_parse (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire msp_pkg::in_item_t  item,
  input  wire logic               advance,
  input  wire msp_pkg::cfg_wr_t   cfg,
  output logic                    out_valid,
  output msp_pkg::result_t        result
);

  // Configuration
  logic [msp_pkg::LEN_W-1:0]  max_length;
  logic [msp_pkg::BYTE_W-1:0] expected_direction;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_length <= msp_pkg::MAX_LEN_RESET;
      expected_direction <= msp_pkg::DIR_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        msp_pkg::REG_MAX_LENGTH: max_length <= cfg.data[msp_pkg::LEN_W-1:0];
        msp_pkg::REG_EXP_DIR:    expected_direction <= cfg.data;
        default: ;
      endcase
    end
  end

  // Parser state
  msp_pkg::phase_t            phase, phase_next;
  logic [msp_pkg::LEN_W-1:0]  held_length, held_length_next;
  logic [msp_pkg::BYTE_W-1:0] held_command, held_command_next;
  logic [msp_pkg::BYTE_W-1:0] running_xor, running_xor_next;
  logic [msp_pkg::LEN_W-1:0]  payload_count, payload_count_next;

  logic                       emit;
  msp_pkg::result_t           res;

  logic [msp_pkg::BYTE_W-1:0] b;
  logic [msp_pkg::LEN_W-1:0]  limit;
  logic                       len_bad;
  logic [msp_pkg::LEN_W-1:0]  count_inc;
  msp_pkg::phase_t            restart;

  assign b = item.rx_byte;
  assign limit = (max_length > msp_pkg::LEN_CAP) ? msp_pkg::LEN_CAP : max_length;
  assign len_bad = b > msp_pkg::BYTE_W'(limit);
  assign count_inc = payload_count + msp_pkg::LEN_W'(1);
  assign restart = (b == msp_pkg::START_BYTE) ? msp_pkg::PH_PROTO : msp_pkg::PH_HUNT;

  // Next phase
  always_comb begin
    phase_next = phase;
    unique case (phase)
      msp_pkg::PH_PROTO: phase_next = (b == msp_pkg::PROTO_BYTE) ? msp_pkg::PH_DIR : restart;
      msp_pkg::PH_DIR:   phase_next = (b == expected_direction) ? msp_pkg::PH_LEN : restart;
      msp_pkg::PH_LEN:   phase_next = len_bad ? msp_pkg::PH_HUNT : msp_pkg::PH_CMD;
      msp_pkg::PH_CMD: begin
        phase_next = (held_length == '0) ? msp_pkg::PH_SUM : msp_pkg::PH_DATA;
      end
      msp_pkg::PH_DATA: begin
        if (count_inc >= held_length) begin
          phase_next = msp_pkg::PH_SUM;
        end
      end
      msp_pkg::PH_SUM:   phase_next = msp_pkg::PH_HUNT;
      default:           phase_next = restart;
    endcase
  end

  // Held fields and result
  always_comb begin
    held_length_next = held_length;
    held_command_next = held_command;
    running_xor_next = running_xor;
    payload_count_next = payload_count;
    emit = 1'b0;
    res.kind = msp_pkg::KIND_PAYLOAD;
    res.command = held_command;
    res.data_byte = b;
    res.byte_index = '0;
    res.frame_length = held_length;
    unique case (phase)
      msp_pkg::PH_LEN: begin
        if (len_bad) begin
          emit = 1'b1;
          res.kind = msp_pkg::KIND_LEN_ERR;
          res.command = '0;
          res.frame_length = '0;
        end else begin
          held_length_next = b[msp_pkg::LEN_W-1:0];
          running_xor_next = b;
          payload_count_next = '0;
        end
      end
      msp_pkg::PH_CMD: begin
        held_command_next = b;
        running_xor_next = running_xor ^ b;
        payload_count_next = '0;
      end
      msp_pkg::PH_DATA: begin
        emit = 1'b1;
        res.byte_index = payload_count;
        running_xor_next = running_xor ^ b;
        payload_count_next = count_inc;
      end
      msp_pkg::PH_SUM: begin
        emit = 1'b1;
        res.kind = (b == running_xor) ? msp_pkg::KIND_GOOD : msp_pkg::KIND_SUM_ERR;
      end
      default: ;
    endcase
  end

  logic take;
  assign take = item.valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= msp_pkg::PH_HUNT;
      held_length <= '0;
      held_command <= '0;
      running_xor <= '0;
      payload_count <= '0;
    end else if (take) begin
      phase <= phase_next;
      held_length <= held_length_next;
      held_command <= held_command_next;
      running_xor <= running_xor_next;
      payload_count <= payload_count_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= take && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      result <= res;
    end
  end

endmodule
`default_nettype wire

>>> design/msp_v1_response_parser.sv
// Serial-protocol v1 response parser. Each item on the s_ side is one received byte; the
// block hunts for '$' 'M' <direction> <length> <command> <payload...> <checksum> and emits
// one item per payload byte (kind 0, with its index) and one status item at the checksum
// byte (kind 1 good, kind 2 checksum error). A length above min(max_length, 31) gives a
// kind 3 item at once and the frame is dropped. Header bytes that do not match send the
// parser back to hunting, with '$' restarting the header; payload and checksum bytes are
// never taken as '$'. Throughput is one byte per clock: an input register feeds the
// combinational parse logic into a result register, so each accepted byte goes through
// both registers before its result is valid, and only a stalled m_ side holds off the s_ side.
// Registers (cfg_index): 0 max_length (5 bit, reset 31), 1 expected_direction (8 bit,
// reset '>'). Write them only while the block is idle; cfg_ready is always high.
`default_nettype none
module msp_v1_response_parser (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // Byte stream in
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  input  wire logic [7:0]                     s_tdata,   // [7:0] rx_byte
  // Result stream out
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  output logic [31:0]                         m_tdata,   // [7:0] command, [15:8] data_byte,
                                                         // [20:16] byte_index,
                                                         // [25:21] frame_length, rest zero
  output logic [1:0]                          m_tuser,   // [1:0] kind
  // Register writes
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [msp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [msp_pkg::CFG_DATA_W-1:0] cfg_data
);

  msp_pkg::in_item_t item;
  msp_pkg::cfg_wr_t  cfg;
  msp_pkg::result_t  result;
  logic              advance;

  // Parse stage moves whenever the result register is empty or being drained
  assign advance = !m_tvalid || m_tready;

  assign cfg_ready = 1'b1;
  assign cfg.valid = cfg_valid;
  assign cfg.index = cfg_index;
  assign cfg.data = cfg_data;

  msp_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .rx_byte  (s_tdata),
    .advance  (advance),
    .item     (item)
  );

  msp_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .advance   (advance),
    .cfg       (cfg),
    .out_valid (m_tvalid),
    .result    (result)
  );

  assign m_tdata = {6'd0, result.frame_length, result.byte_index,
                    result.data_byte, result.command};
  assign m_tuser = result.kind;

endmodule
`default_nettype wire

>>> design/msp_chk.sv
`default_nettype none
module msp_chk (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [31:0] m_tdata,
  input wire logic [1:0]  m_tuser
);

  logic [7:0] command;
  logic [4:0] byte_index;
  logic [4:0] frame_length;

  assign command = m_tdata[7:0];
  assign byte_index = m_tdata[20:16];
  assign frame_length = m_tdata[25:21];

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // Payload index stays inside the announced length
  a_index: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == msp_pkg::KIND_PAYLOAD |-> byte_index < frame_length)
    else $error("payload index beyond frame length");

  // Length rejection carries no frame context
  a_len_err: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == msp_pkg::KIND_LEN_ERR
      |-> command == 8'd0 && frame_length == 5'd0 && byte_index == 5'd0)
    else $error("length error carries frame fields");

  // Status items carry index zero
  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == msp_pkg::KIND_GOOD || m_tuser == msp_pkg::KIND_SUM_ERR)
      |-> byte_index == 5'd0)
    else $error("status item with nonzero index");

endmodule

bind msp_v1_response_parser msp_chk u_msp_chk (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
`default_nettype wire
